>>> rtl/pi2_pkg.sv
// shared types and constants for the 2x2 power iteration block
package pi2_pkg;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_A,
    ST_MUL_B,
    ST_ZCHK,
    ST_DIV_MU,
    ST_NORM,
    ST_SQRT,
    ST_DIV_X,
    ST_DIV_Y,
    ST_UPDATE,
    ST_DONE
  } pi2_state_t;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_M00    = 3'd0;
  localparam logic [2:0] REG_M01    = 3'd1;
  localparam logic [2:0] REG_M10    = 3'd2;
  localparam logic [2:0] REG_M11    = 3'd3;
  localparam logic [2:0] REG_ROUNDS = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take start vector
    logic mul_a;     // products stage one
    logic mul_b;     // sums stage two
    logic mu_start;  // start mu divide
    logic norm;      // one normalising shift step
    logic sqrt_start;
    logic dx_start;
    logic dy_start;
    logic update;    // new vector into work registers
    logic zero_out;  // flag zero case
  } pi2_cmd_t;

  // status from the datapath
  typedef struct packed {
    logic bb_zero;
    logic ab_zero;
    logic norm_done;
    logic div_busy;
    logic sqrt_busy;
  } pi2_stat_t;

endpackage

>>> rtl/pi2_div.sv
// restoring unsigned divider, one quotient bit a cycle
module pi2_div #(
  parameter int W = 96
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  // one shift and subtract step
  always_comb begin
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[W-1:0], q_r[W-1]};
    trial    = shifted - {1'b0, d_r};
    if (start) begin
      q_nxt    = num;
      d_nxt    = den;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule

>>> rtl/pi2_sqrt.sv
// bit-pair integer square root of a 64-bit value, one step a cycle
module pi2_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] n_r, n_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] sum;

  // one step of the digit recurrence
  always_comb begin
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    sum      = {1'b0, res_r} + {1'b0, bit_r};
    if (start) begin
      n_nxt    = val;
      res_nxt  = '0;
      bit_nxt  = 64'd1 << 62;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, n_r} >= sum) begin
        n_nxt   = n_r - sum[63:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[31:0];
endmodule

>>> rtl/pi2_datapath.sv
// datapath: matrix products, mu, normalisation and division units
module pi2_datapath #(
  parameter int FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pi2_pkg::pi2_cmd_t   cmd,
  output pi2_pkg::pi2_stat_t  st,
  input  logic signed [15:0]  m00,
  input  logic signed [15:0]  m01,
  input  logic signed [15:0]  m10,
  input  logic signed [15:0]  m11,
  input  logic signed [15:0]  start_x,
  input  logic signed [15:0]  start_y,
  output logic signed [31:0]  eigen_estimate,
  output logic signed [15:0]  vec_x,
  output logic signed [15:0]  vec_y,
  output logic [1:0]          status
);
  import pi2_pkg::*;

  localparam int DW = 96;

  logic signed [31:0] bx_r, by_r;
  logic signed [47:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [48:0] abx_r, aby_r;
  logic signed [63:0] xx_r, yy_r;
  logic signed [81:0] mu1_r;
  logic [64:0]        bb_r;
  logic [63:0]        ux_r, uy_r, n2_r;
  logic [4:0]         s_r;
  logic               neg_mu_r, negx_r, negy_r;
  logic signed [31:0] mu_r;
  logic               sat_r, zero_r;
  logic signed [15:0] vx_r, vy_r;
  logic [1:0]         phase_r;
  logic signed [15:0] ma, mb;
  logic signed [31:0] va;
  logic [DW-1:0]      dnum, dden, quo;
  logic               div_busy, sq_busy;
  logic [31:0]        root;
  logic [DW-1:0]      mu_num, mu_den, q;
  logic [63:0]        ax, ay;
  logic               dstart;
  logic signed [15:0] bxs, bys;
  logic signed [33:0] abxs, abys;
  logic signed [49:0] bab_x, bab_y;
  logic [63:0]        sq_x, sq_y;

  // magnitudes of ab, widened to 64 bits for normalisation
  assign ax = abx_r[48] ? 64'(-abx_r) : 64'(abx_r);
  assign ay = aby_r[48] ? 64'(-aby_r) : 64'(aby_r);

  // b always fits 16 bits and Ab 34 bits, so the second stage products stay narrow
  assign bxs   = bx_r[15:0];
  assign bys   = by_r[15:0];
  assign abxs  = abx_r[33:0];
  assign abys  = aby_r[33:0];
  assign bab_x = 50'(bxs) * 50'(abxs);
  assign bab_y = 50'(bys) * 50'(abys);
  assign sq_x  = 64'(ax[31:0]) * 64'(ax[31:0]);
  assign sq_y  = 64'(ay[31:0]) * 64'(ay[31:0]);

  // mu operands: |b.Ab| << 16 over b.b << FRAC_BITS
  assign mu_num = DW'(mu1_r[81] ? -mu1_r : mu1_r) << 16;
  assign mu_den = DW'(bb_r) << FRAC_BITS;

  // divider operand select
  always_comb begin
    dnum = mu_num;
    dden = mu_den;
    if (cmd.dx_start) begin
      dnum = DW'(ux_r) << 14;
      dden = DW'(root);
    end else if (cmd.dy_start) begin
      dnum = DW'(uy_r) << 14;
      dden = DW'(root);
    end
  end
  assign dstart = cmd.mu_start | cmd.dx_start | cmd.dy_start;

  pi2_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .busy(div_busy), .quo(quo)
  );

  pi2_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start), .val(n2_r),
    .busy(sq_busy), .root(root)
  );

  assign q = quo;

  // shared multiplier operands follow the sequencing phase
  always_comb begin
    ma = m00;
    mb = m01;
    va = bx_r;
    case (phase_r)
      2'd0: begin ma = m00; mb = m10; va = bx_r; end
      2'd1: begin ma = m01; mb = m11; va = by_r; end
      default: begin ma = m00; mb = m10; va = bx_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      zero_r  <= 1'b0;
      sat_r   <= 1'b0;
      bx_r    <= '0;
      by_r    <= '0;
    end else begin
      // start vector
      if (cmd.load) begin
        bx_r    <= 32'(start_x);
        by_r    <= 32'(start_y);
        zero_r  <= 1'b0;
        sat_r   <= 1'b0;
        mu_r    <= '0;
        vx_r    <= '0;
        vy_r    <= '0;
        phase_r <= 2'd0;
      end
      // products: two matrix columns, one per phase
      if (cmd.mul_a) begin
        if (phase_r == 2'd0) begin
          p00_r   <= 48'(ma * va);
          p10_r   <= 48'(mb * va);
          xx_r    <= 64'(bx_r * bx_r);
          phase_r <= 2'd1;
        end else begin
          p01_r   <= 48'(ma * va);
          p11_r   <= 48'(mb * va);
          yy_r    <= 64'(by_r * by_r);
          phase_r <= 2'd0;
        end
      end
      // sums, then b.Ab from the registered Ab
      if (cmd.mul_b) begin
        if (phase_r == 2'd0) begin
          abx_r   <= 49'(p00_r) + 49'(p01_r);
          aby_r   <= 49'(p10_r) + 49'(p11_r);
          bb_r    <= 65'(xx_r) + 65'(yy_r);
          phase_r <= 2'd1;
        end else begin
          mu1_r   <= 82'(bab_x) + 82'(bab_y);
          ux_r    <= ax;
          uy_r    <= ay;
          n2_r    <= sq_x + sq_y;
          negx_r  <= abx_r[48];
          negy_r  <= aby_r[48];
          neg_mu_r <= 1'b0;
          s_r     <= '0;
          phase_r <= 2'd0;
        end
      end
      if (cmd.mu_start) neg_mu_r <= mu1_r[81];
      // normalising shift: n2 by two bits and ux, uy by one bit per step
      if (cmd.norm) begin
        n2_r <= n2_r << 2;
        ux_r <= ux_r << 1;
        uy_r <= uy_r << 1;
        s_r  <= s_r + 5'd1;
      end
      // mu result with saturation, taken when the square root starts or on the first zero flag
      // a zero start vector has no quotient and gives mu of zero
      if (cmd.sqrt_start || (cmd.zero_out && !zero_r)) begin
        if (bb_r == '0) begin
          mu_r <= '0; sat_r <= 1'b0;
        end else if (neg_mu_r) begin
          if (q > DW'(32'h8000_0000)) begin
            mu_r <= 32'sh8000_0000; sat_r <= 1'b1;
          end else begin
            mu_r <= 32'(-q); sat_r <= 1'b0;
          end
        end else begin
          if (q > DW'(32'h7fff_ffff)) begin
            mu_r <= 32'sh7fff_ffff; sat_r <= 1'b1;
          end else begin
            mu_r <= 32'(q); sat_r <= 1'b0;
          end
        end
      end
      if (cmd.dy_start) vx_r <= negx_r ? -16'(quo) : 16'(quo);
      if (cmd.update) begin
        vy_r <= negy_r ? -16'(quo) : 16'(quo);
        bx_r <= 32'(vx_r);
        by_r <= negy_r ? -32'(quo) : 32'(quo);
      end
      if (cmd.zero_out) zero_r <= 1'b1;
    end
  end

  // status back to the controller
  always_comb begin
    st.bb_zero   = (bb_r == '0);
    st.ab_zero   = (n2_r == '0);
    st.norm_done = n2_r[63] | n2_r[62] | n2_r[61] | n2_r[60] | (s_r == 5'd31);
    st.div_busy  = div_busy;
    st.sqrt_busy = sq_busy;
  end

  // result word
  always_comb begin
    eigen_estimate = mu_r;
    vec_x          = zero_r ? 16'sd0 : vx_r;
    vec_y          = zero_r ? 16'sd0 : vy_r;
    status         = zero_r ? STAT_ZERO : (sat_r ? STAT_SAT : STAT_OK);
  end
endmodule

>>> rtl/pi2_ctrl.sv
// controller state machine sequencing rounds through the datapath
module pi2_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_fire,
  input  logic [7:0]         round_count,
  input  pi2_pkg::pi2_stat_t st,
  output pi2_pkg::pi2_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import pi2_pkg::*;

  pi2_state_t state_r, state_nxt;
  logic [7:0] rnd_r, rnd_nxt;
  logic       ph_r, ph_nxt;
  logic       zmu_r, zmu_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    ph_nxt    = ph_r;
    zmu_nxt   = zmu_r;
    case (state_r)
      ST_IDLE: if (in_fire) begin
        state_nxt = ST_LOAD;
        rnd_nxt   = (round_count == 8'd0) ? 8'd1 : round_count;
      end
      ST_LOAD: begin state_nxt = ST_MUL_A; ph_nxt = 1'b0; end
      ST_MUL_A: begin
        ph_nxt = ~ph_r;
        if (ph_r) state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        ph_nxt = ~ph_r;
        if (ph_r) state_nxt = ST_ZCHK;
      end
      ST_ZCHK: begin
        zmu_nxt = 1'b0;
        if (st.bb_zero) state_nxt = ST_DONE;
        else begin
          state_nxt = ST_DIV_MU;
          zmu_nxt   = 1'b1;
        end
      end
      ST_DIV_MU: begin
        zmu_nxt = 1'b0;
        if (!zmu_r && !st.div_busy)
          state_nxt = st.ab_zero ? ST_DONE : ST_NORM;
      end
      ST_NORM: if (st.norm_done) state_nxt = ST_SQRT;
      ST_SQRT: begin
        zmu_nxt = 1'b0;
        if (zmu_r) zmu_nxt = 1'b0;
        else if (!st.sqrt_busy && ph_r) begin
          state_nxt = ST_DIV_X; zmu_nxt = 1'b1; ph_nxt = 1'b0;
        end else ph_nxt = 1'b1;
      end
      ST_DIV_X: begin
        zmu_nxt = 1'b0;
        if (!zmu_r && !st.div_busy) begin state_nxt = ST_DIV_Y; zmu_nxt = 1'b1; end
      end
      ST_DIV_Y: begin
        zmu_nxt = 1'b0;
        if (!zmu_r && !st.div_busy) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        rnd_nxt = rnd_r - 8'd1;
        ph_nxt  = 1'b0;
        state_nxt = (rnd_r == 8'd1) ? ST_DONE : ST_MUL_A;
      end
      ST_DONE: if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    done = (state_r == ST_DONE);
    case (state_r)
      // start vector is taken on the accepting edge itself
      ST_IDLE:   cmd.load = in_fire;
      ST_MUL_A:  cmd.mul_a = 1'b1;
      ST_MUL_B:  cmd.mul_b = 1'b1;
      ST_ZCHK: begin
        if (st.bb_zero) cmd.zero_out = 1'b1;
        else cmd.mu_start = 1'b1;
      end
      ST_DIV_MU: if (!zmu_r && !st.div_busy && st.ab_zero) cmd.zero_out = 1'b1;
      ST_NORM:   if (!st.norm_done) cmd.norm = 1'b1;
      ST_SQRT:   if (!zmu_r && !ph_r) cmd.sqrt_start = 1'b1;
      ST_DIV_X:  if (zmu_r) cmd.dx_start = 1'b1;
      ST_DIV_Y:  if (zmu_r) cmd.dy_start = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      ph_r    <= 1'b0;
      zmu_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      ph_r    <= ph_nxt;
      zmu_r   <= zmu_nxt;
    end
  end

  // sequencing checks
  a_load_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> $past(state_r) == ST_IDLE)
    else $error("load without start");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mu_start, cmd.dx_start, cmd.dy_start}))
    else $error("divider started twice");
  a_rounds_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> rnd_r != 8'd0)
    else $error("round counter underflow");
endmodule

>>> rtl/power_iteration_2x2.sv
// top level of the 2x2 power iteration block
// Each input word is a start vector; the block runs round_count rounds (zero
// counts as one) of power iteration on the configured matrix and returns one
// word with the final Rayleigh quotient and unit vector. One item at a time:
// each round uses the 96-step shared divider three times, the 32-step square
// root, the normalising shifts and the products and sequencing, and the next
// item is not taken while the output word waits for out_tready.
module power_iteration_2x2 #(
  parameter int FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // start_x, start_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // eigen_estimate, vec_x, vec_y, status, zero pad
);
  import pi2_pkg::*;

  logic signed [15:0] m00_r, m01_r, m10_r, m11_r;
  logic [7:0]         rounds_r;
  pi2_cmd_t           cmd;
  pi2_stat_t          st;
  logic               busy, done;
  logic signed [31:0] eig;
  logic signed [15:0] vx, vy;
  logic [1:0]         stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m00_r    <= 16'sd20480;
      m01_r    <= 16'sd4096;
      m10_r    <= -16'sd4096;
      m11_r    <= 16'sd12288;
      rounds_r <= 8'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_M00:    m00_r    <= cfg_data;
        REG_M01:    m01_r    <= cfg_data;
        REG_M10:    m10_r    <= cfg_data;
        REG_M11:    m11_r    <= cfg_data;
        REG_ROUNDS: rounds_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_tready  = !busy;
  assign out_tvalid = done;

  pi2_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .out_fire(out_tvalid && out_tready), .round_count(rounds_r),
    .st(st), .cmd(cmd), .busy(busy), .done(done)
  );

  pi2_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .m00(m00_r), .m01(m01_r), .m10(m10_r), .m11(m11_r),
    .start_x(in_tdata[15:0]), .start_y(in_tdata[31:16]),
    .eigen_estimate(eig), .vec_x(vx), .vec_y(vy), .status(stat)
  );

  assign out_tdata = {6'd0, stat, vy, vx, eig};
endmodule

>>> bench/pi2_checker.sv
// checker for the 2x2 power iteration block: predicts and compares output words
module pi2_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          fail_count,
  output int          words_pending,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import pi2_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] vec_y;
    logic [15:0] vec_x;
    logic [31:0] eigen;
  } eig_word_t;

  // mirrored registers and working vector
  logic signed [15:0] mat00, mat01, mat10, mat11;
  logic [7:0]         rounds_cfg;
  longint             cur_x, cur_y;

  eig_word_t expected_words[$];

  function automatic longint unsigned abs_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // run all rounds on one start vector
  function automatic eig_word_t iterate_vector(logic [15:0] sx, logic [15:0] sy);
    longint bx, by, abx, aby, mu1, mu, vx, vy;
    longint unsigned mu2, num, den, q, ux, uy, n2, nrm;
    int s, nrounds;
    bit sat;
    logic [1:0] st;
    eig_word_t w;
    nrounds = (rounds_cfg == 0) ? 1 : rounds_cfg;
    mu = 0; vx = 0; vy = 0; sat = 0; st = STAT_OK;
    cur_x = longint'($signed(sx));
    cur_y = longint'($signed(sy));
    for (int r = 0; r < nrounds; r++) begin
      bx = cur_x;
      by = cur_y;
      abx = longint'(mat00) * bx + longint'(mat01) * by;
      aby = longint'(mat10) * bx + longint'(mat11) * by;
      mu1 = bx * abx + by * aby;
      mu2 = bx * bx + by * by;
      if (mu2 == 0) begin
        mu = 0;
        st = STAT_ZERO;
        break;
      end
      // the numerator wraps at 64 bits here; the block's divider operands are 96 bits wide
      num = abs_of(mu1) << 16;
      den = mu2 << 12;
      q = num / den;
      sat = 0;
      if (mu1 < 0) begin
        if (q > 64'h8000_0000) begin q = 64'h8000_0000; sat = 1; end
        mu = -longint'(q);
      end else begin
        if (q > 64'h7FFF_FFFF) begin q = 64'h7FFF_FFFF; sat = 1; end
        mu = longint'(q);
      end
      ux = abs_of(abx);
      uy = abs_of(aby);
      n2 = ux * ux + uy * uy;
      if (n2 == 0) begin
        st = STAT_ZERO;
        break;
      end
      s = 0;
      while (n2 < (64'd1 << 60) && s < 31) begin
        n2 <<= 2;
        s++;
      end
      ux <<= s;
      uy <<= s;
      nrm = int_sqrt(n2);
      vx = longint'((ux << 14) / nrm);
      vy = longint'((uy << 14) / nrm);
      if (abx < 0) vx = -vx;
      if (aby < 0) vy = -vy;
      cur_x = longint'($signed(vx[31:0]));
      cur_y = longint'($signed(vy[31:0]));
    end
    if (st == STAT_ZERO) begin
      vx = 0;
      vy = 0;
    end else if (sat) begin
      st = STAT_SAT;
    end
    w.eigen = mu[31:0];
    w.vec_x = vx[15:0];
    w.vec_y = vy[15:0];
    w.status = st;
    return w;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on word %0d: %s got %0d expected %0d",
             words_checked, field, got, want);
    fail_count++;
  endtask

  // watch configuration, input and output words
  always @(posedge clk) begin
    eig_word_t got, want;
    if (!rst_n) begin
      mat00 = 16'sd20480;
      mat01 = 16'sd4096;
      mat10 = -16'sd4096;
      mat11 = 16'sd12288;
      rounds_cfg = 8'd60;
      cur_x = 0;
      cur_y = 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_M00:    mat00 = cfg_data;
          REG_M01:    mat01 = cfg_data;
          REG_M10:    mat10 = cfg_data;
          REG_M11:    mat11 = cfg_data;
          REG_ROUNDS: rounds_cfg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_words.push_back(iterate_vector(in_tdata[15:0], in_tdata[31:16]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[65:0];
        if (expected_words.size() == 0) begin
          $display("unexpected output word %0d", words_checked);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.eigen !== want.eigen)
            report_mismatch("eigen_estimate", $signed(got.eigen), $signed(want.eigen));
          if (got.vec_x !== want.vec_x)
            report_mismatch("vec_x", $signed(got.vec_x), $signed(want.vec_x));
          if (got.vec_y !== want.vec_y)
            report_mismatch("vec_y", $signed(got.vec_y), $signed(want.vec_y));
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        end
        words_checked++;
      end
    end
    words_pending = expected_words.size();
  end

  initial begin
    fail_count = 0;
    words_pending = 0;
    words_checked = 0;
  end
endmodule

>>> bench/tb_top.sv
// testbench top for the 2x2 power iteration block: stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pi2_pkg::*;

  localparam int IDLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // start_x, start_y
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // eigen_estimate, vec_x, vec_y, status, zero pad

  int fail_count, words_pending, words_checked;
  int burst_left;
  int idle_cycles;
  int vectors_sent;

  power_iteration_2x2 i_dut (.*);

  pi2_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls: stretches of always-ready, random and mostly-stalled
  initial begin
    int mode, span;
    out_tready = 0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(1, 60);
      repeat (span) @(posedge clk) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d, logic [15:0] rounds);
    write_reg(REG_M00, a);
    write_reg(REG_M01, b);
    write_reg(REG_M10, c);
    write_reg(REG_M11, d);
    write_reg(REG_ROUNDS, rounds);
  endtask

  // send one start vector, bursts separated by random gaps
  task automatic send_vector(logic [15:0] sx, logic [15:0] sy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 6);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {sy, sx};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    vectors_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(0, 16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] a, b;
    int nrounds;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 0;
    in_tdata = '0;
    burst_left = 0;
    idle_cycles = 0;
    vectors_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix and 60 rounds: zero vector, extremes, unit vectors
    send_vector(16'h0000, 16'h0000);
    send_vector(16'h7FFF, 16'h7FFF);
    send_vector(16'h8000, 16'h8000);
    send_vector(16'h1000, 16'h0000);
    send_vector(16'h0000, 16'h1000);
    send_vector(16'h8000, 16'h7FFF);
    drain_results();

    // extreme matrices, one and two rounds
    load_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd1);
    send_vector(16'h8000, 16'h8000);
    send_vector(16'h7FFF, 16'h8000);
    send_vector(16'h0001, 16'hFFFF);
    drain_results();
    load_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd2);
    send_vector(16'h7FFF, 16'h7FFF);
    send_vector(16'h1000, 16'hF000);   // singular direction: zero product
    send_vector(16'h8000, 16'h0001);
    drain_results();
    // zero matrix gives zero product; round count zero counts as one
    load_matrix(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    send_vector(16'h1234, 16'h8765);
    send_vector(16'h0000, 16'h0000);
    drain_results();
    // out-of-list index is ignored; longest round count
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd7, 16'h1234);
    load_matrix(16'h1000, 16'h2000, 16'hE000, 16'h7FFF, 16'd255);
    send_vector(16'h0800, 16'h8000);
    drain_results();

    // random phases, mostly short round counts
    for (int phase = 0; phase < 6; phase++) begin
      nrounds = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) begin
        a = pick_value();
        load_matrix(a, a, a, a, 16'(nrounds));
      end else begin
        load_matrix(pick_value(), pick_value(), pick_value(), pick_value(),
                    {8'($urandom_range(0, 255)), 8'(nrounds)});
      end
      if ($urandom_range(0, 1)) write_reg(3'($urandom_range(5, 7)), 16'($urandom));
      for (int k = 0; k < 22; k++) begin
        a = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
        b = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
        if ($urandom_range(0, 7) == 0) b = -a;
        send_vector(a, b);
      end
      drain_results();
    end

    $display("sent %0d start vectors, checked %0d output words", vectors_sent, words_checked);
    $display("covered zero vectors, zero products, extreme matrices and round counts 0 to 255");
    if (fail_count == 0 && words_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/pi2_pkg.sv
rtl/pi2_div.sv
rtl/pi2_sqrt.sv
rtl/pi2_datapath.sv
rtl/pi2_ctrl.sv
rtl/power_iteration_2x2.sv
bench/pi2_checker.sv
bench/tb_top.sv
